// ===== rtl/ihs_pkg.sv =====
// ihs_pkg: shared types, register indexes and constants for the int8
// hard-swish activation block. No dependencies.
package ihs_pkg;

	// Configuration port geometry
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// Register indexes on the configuration port
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IN_ZERO_POINT   = 3'd0,
		REG_OUT_SCALE_MULT  = 3'd1,
		REG_GATE_SCALE_MULT = 3'd2,
		REG_GATE_SCALE_EXP  = 3'd3,
		REG_OUT_SHIFT_EXP   = 3'd4,
		REG_OUT_ZERO_POINT  = 3'd5
	} reg_idx_t;

	// Fixed-point constants
	localparam logic signed [31:0] Q15_ROUND  = 32'sd16384;
	localparam logic signed [31:0] Q15_TRUNC  = 32'sd32767;
	localparam logic signed [15:0] Q15_MAX    = 16'sd32767;
	localparam logic signed [15:0] Q15_MIN    = -16'sd32768;
	localparam logic signed [16:0] INT8_MAX17 = 17'sd127;
	localparam logic signed [16:0] INT8_MIN17 = -17'sd128;

	// Register reset values
	localparam logic signed [15:0] MULT_RST = 16'sd16384;

	// Input beat
	typedef struct packed {
		logic signed [7:0] sample;
		logic              last_in;
	} ihs_in_t;

	// Result beat
	typedef struct packed {
		logic signed [7:0] result;
		logic              last_out;
	} ihs_out_t;

	// Configuration register set
	typedef struct packed {
		logic signed [7:0]  in_zero_point;
		logic signed [15:0] out_scale_mult;
		logic signed [15:0] gate_scale_mult;
		logic signed [4:0]  gate_scale_exp;
		logic signed [4:0]  out_shift_exp;
		logic signed [7:0]  out_zero_point;
	} ihs_cfg_t;

endpackage

// ===== rtl/ihs_datapath.sv =====
// ihs_datapath: eight-stage hard-swish arithmetic pipeline with valid bits.
// Depends on ihs_pkg (beat and configuration types, constants).
module ihs_datapath (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  ihs_pkg::ihs_cfg_t cfg,
	input  logic              in_valid,
	input  ihs_pkg::ihs_in_t  in_data,
	output logic              s8_valid,
	output ihs_pkg::ihs_out_t s8_data
);

	// Saturate a wide signed value to 16 bits
	function automatic logic signed [15:0] sat16(input logic signed [30:0] v);
		logic signed [15:0] r;
		if (v > 31'sd32767)
			r = ihs_pkg::Q15_MAX;
		else if (v < -31'sd32768)
			r = ihs_pkg::Q15_MIN;
		else
			r = v[15:0];
		return r;
	endfunction

	// Divide by 2^e, halves rounded away from zero
	function automatic logic signed [15:0] rnd_div_pot(input logic signed [15:0] v,
			input logic [4:0] e);
		logic [16:0]        mask;
		logic [16:0]        rem;
		logic [16:0]        thr;
		logic signed [15:0] q;
		mask = (17'd1 << e) - 17'd1;
		rem  = {v[15], v} & mask;
		thr  = {1'b0, mask[16:1]} + {16'd0, v[15]};
		q    = v >>> e;
		return (rem > thr) ? q + 16'sd1 : q;
	endfunction

	// Valid and last flags travel with the data
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;
	logic last_s1, last_s2, last_s3, last_s4, last_s5, last_s6, last_s7, last_s8;

	logic signed [15:0] hires_s1, gpre_s1;
	logic signed [31:0] ps_s2, pg_s2;
	logic               gspec_s2;
	logic signed [15:0] scaled_s3, g2_s3;
	logic signed [15:0] scaled_s4;
	logic [14:0]        gate_s4;
	logic signed [31:0] pm_s5;
	logic signed [15:0] prod_s6;
	logic signed [15:0] rnd_s7;
	logic signed [7:0]  res_s8;

	// Stage 1: remove zero point, scale by 128, optional gate pre-shift
	logic signed [8:0]  diff;
	logic signed [15:0] hires;
	logic [3:0]         gshift;
	logic signed [30:0] gwide;
	logic               gexp_pos;
	logic signed [15:0] gpre;

	assign diff     = $signed({in_data.sample[7], in_data.sample})
	                - $signed({cfg.in_zero_point[7], cfg.in_zero_point});
	assign hires    = {diff, 7'd0};
	assign gexp_pos = !cfg.gate_scale_exp[4] && (cfg.gate_scale_exp != 5'sd0);
	assign gshift   = cfg.gate_scale_exp[3:0] - 4'd1;
	assign gwide    = $signed({{15{hires[15]}}, hires}) <<< gshift;
	assign gpre     = gexp_pos ? sat16(gwide) : hires;

	// Stage 2: Q15 multiplies
	logic signed [31:0] ps_c, pg_c;
	assign ps_c = hires_s1 * cfg.out_scale_mult;
	assign pg_c = gpre_s1 * cfg.gate_scale_mult;

	// Stage 3: rounding high halves
	logic signed [31:0] sum_s, sum_g;
	assign sum_s = ps_s2 + ihs_pkg::Q15_ROUND;
	assign sum_g = pg_s2 + ihs_pkg::Q15_ROUND;

	// Stage 4: gate exponent, then map [-1,1] to [0,1]
	logic [4:0]         gneg;
	logic signed [15:0] g3;
	assign gneg = 5'(-cfg.gate_scale_exp);
	always_comb begin
		if (gexp_pos)
			g3 = sat16($signed({{15{g2_s3[15]}}, g2_s3}) <<< 1);
		else if (cfg.gate_scale_exp[4])
			g3 = rnd_div_pot(g2_s3, gneg);
		else
			g3 = g2_s3;
	end

	// Stage 5: gate times scaled input
	logic signed [31:0] pm_c;
	assign pm_c = $signed({1'b0, gate_s4}) * scaled_s4;

	// Stage 6: high half truncated toward zero
	logic signed [31:0] tr;
	assign tr = pm_s5 + (pm_s5[31] ? ihs_pkg::Q15_TRUNC : 32'sd0);

	// Stage 7: final rounding right shift
	logic [4:0] oshift;
	assign oshift = cfg.out_shift_exp[4] ? 5'(-cfg.out_shift_exp) : 5'd0;

	// Stage 8: add output zero point and clamp
	logic signed [16:0] ysum;
	logic signed [16:0] yclamp;
	assign ysum = $signed({rnd_s7[15], rnd_s7})
	            + $signed({{9{cfg.out_zero_point[7]}}, cfg.out_zero_point});
	always_comb begin
		if (ysum > ihs_pkg::INT8_MAX17)
			yclamp = ihs_pkg::INT8_MAX17;
		else if (ysum < ihs_pkg::INT8_MIN17)
			yclamp = ihs_pkg::INT8_MIN17;
		else
			yclamp = ysum;
	end

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (en) begin
			hires_s1  <= hires;
			gpre_s1   <= gpre;
			last_s1   <= in_data.last_in;

			ps_s2     <= ps_c;
			pg_s2     <= pg_c;
			gspec_s2  <= (gpre_s1 == ihs_pkg::Q15_MIN)
			          && (cfg.gate_scale_mult == ihs_pkg::Q15_MIN);
			last_s2   <= last_s1;

			scaled_s3 <= sum_s[30:15];
			g2_s3     <= gspec_s2 ? ihs_pkg::Q15_MAX : sum_g[30:15];
			last_s3   <= last_s2;

			scaled_s4 <= scaled_s3;
			gate_s4   <= {~g3[15], g3[14:1]};
			last_s4   <= last_s3;

			pm_s5     <= pm_c;
			last_s5   <= last_s4;

			prod_s6   <= tr[30:15];
			last_s6   <= last_s5;

			rnd_s7    <= rnd_div_pot(prod_s6, oshift);
			last_s7   <= last_s6;

			res_s8    <= yclamp[7:0];
			last_s8   <= last_s7;
		end
	end

	assign s8_valid         = v_s8;
	assign s8_data.result   = res_s8;
	assign s8_data.last_out = last_s8;

endmodule

// ===== rtl/int8_hard_swish_activation.sv =====
// int8_hard_swish_activation: top level with configuration registers,
// output register and skid slot. Depends on ihs_pkg and ihs_datapath.
//
// Usage:
//  - Input channel in_valid/in_ready/in_data carries one int8 sample and a
//    last flag per beat; output channel out_valid/out_ready/out_data gives
//    one int8 hard-swish result per input beat, with the last flag copied.
//  - Configuration is written through cfg_we/cfg_index/cfg_wdata, one register per cycle;
//    the user must write it only while no beats are in flight; the block does not enforce it.
//  - Path: an accepted beat passes the eight arithmetic stages, the first
//    loaded at the accepting edge, and then the output register before its
//    result shows on out_valid.
//  - Throughput: one beat per cycle while the skid slot is empty, as the
//    eight-stage pipeline advances only then.
//  - Stall: results collect in the output register and one skid slot; once
//    the skid slot holds a result, in_ready drops and the whole pipeline
//    freezes until the receiver takes a beat.
//  - Reset clears all valid bits and restores the register defaults
//    (multipliers 16384, zero points and exponents 0).
module int8_hard_swish_activation (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  ihs_pkg::ihs_in_t                    in_data,
	output logic                                out_valid,
	input  logic                                out_ready,
	output ihs_pkg::ihs_out_t                   out_data,
	input  logic                                cfg_we,
	input  logic [ihs_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [ihs_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

	ihs_pkg::ihs_cfg_t cfg_q;
	ihs_pkg::ihs_out_t out_q, skid_q;
	ihs_pkg::ihs_out_t s8_data;
	logic              out_valid_q, skid_valid_q;
	logic              s8_valid;
	logic              en;
	logic              arr;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.in_zero_point   <= '0;
			cfg_q.out_scale_mult  <= ihs_pkg::MULT_RST;
			cfg_q.gate_scale_mult <= ihs_pkg::MULT_RST;
			cfg_q.gate_scale_exp  <= '0;
			cfg_q.out_shift_exp   <= '0;
			cfg_q.out_zero_point  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ihs_pkg::REG_IN_ZERO_POINT:   cfg_q.in_zero_point   <= cfg_wdata[7:0];
				ihs_pkg::REG_OUT_SCALE_MULT:  cfg_q.out_scale_mult  <= cfg_wdata;
				ihs_pkg::REG_GATE_SCALE_MULT: cfg_q.gate_scale_mult <= cfg_wdata;
				ihs_pkg::REG_GATE_SCALE_EXP:  cfg_q.gate_scale_exp  <= cfg_wdata[4:0];
				ihs_pkg::REG_OUT_SHIFT_EXP:   cfg_q.out_shift_exp   <= cfg_wdata[4:0];
				ihs_pkg::REG_OUT_ZERO_POINT:  cfg_q.out_zero_point  <= cfg_wdata[7:0];
				default: ;
			endcase
		end
	end

	// Pipeline advances unless the skid slot is occupied
	assign en       = ~skid_valid_q;
	assign in_ready = en;
	assign arr      = en & s8_valid;

	ihs_datapath u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.cfg      (cfg_q),
		.in_valid (in_valid),
		.in_data  (in_data),
		.s8_valid (s8_valid),
		.s8_data  (s8_data)
	);

	// Output register and skid slot: control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || out_ready) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= arr;
			end
		end else if (arr) begin
			skid_valid_q <= 1'b1;
		end
	end

	// Output register and skid slot: payload
	always_ff @(posedge clk) begin
		if (!out_valid_q || out_ready) begin
			if (skid_valid_q)
				out_q <= skid_q;
			else if (arr)
				out_q <= s8_data;
		end else if (arr) begin
			skid_q <= s8_data;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// ===== rtl/ihs_checker.sv =====
// ihs_checker: port-level assertions for the int8 hard-swish block, bound
// to the top level below. Depends on ihs_pkg (beat types).
module ihs_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input ihs_pkg::ihs_in_t  in_data,
	input logic              out_valid,
	input logic              out_ready,
	input ihs_pkg::ihs_out_t out_data
);

	// Beats accepted but not yet delivered
	logic [3:0] cnt_q;
	logic       in_acc, out_acc;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			cnt_q <= '0;
		else
			cnt_q <= cnt_q + {3'd0, in_acc} - {3'd0, out_acc};
	end

	// A stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed or dropped while stalled");

	// No result without an accepted beat behind it
	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> cnt_q != 4'd0)
		else $error("result with no beat in flight");

	// Occupancy bounded by pipeline, output register and skid slot
	a_occupancy: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 4'd10)
		else $error("more beats in flight than storage");

	// Input back-pressure only follows an output stall
	a_ready_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> $past(out_valid && !out_ready))
		else $error("in_ready low without output stall");

	// No beat is taken in, with none going out, while every slot already holds one
	a_in_data_seen: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && !out_acc && cnt_q == 4'd10 |-> 1'b0)
		else $error("beat accepted with storage full, last flag %0b", in_data.last_in);

endmodule

bind int8_hard_swish_activation ihs_checker u_ihs_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.in_data   (in_data),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);

// ===== tb/tb_int8_hard_swish_activation.sv =====
// tb_int8_hard_swish_activation: self-checking bench for the int8 hard-swish block.
// A table of probe samples runs first, then planned and random register settings with mostly random samples,
// each result checked against a known value or an in-bench hard-swish predictor. Depends on ihs_pkg.
module tb_int8_hard_swish_activation;

	localparam int CYCLE_LIMIT     = 200000;
	localparam int DRAIN_CYCLES    = 12;
	localparam int N_PHASES        = 15;
	localparam int BEATS_PER_PHASE = 40;
	localparam int N_PROBES        = 18;
	localparam int N_PLANNED       = 5;

	// Indexes past the register list; writes there must change nothing
	localparam logic [ihs_pkg::CFG_IDX_W-1:0] IDX_SPARE_A = 3'd6;
	localparam logic [ihs_pkg::CFG_IDX_W-1:0] IDX_SPARE_B = 3'd7;

	// Probe row: sample, last flag, whether the result is known up front, and that result
	typedef struct packed {
		logic signed [7:0] sample;
		logic              last;
		logic              known;
		logic signed [7:0] want;
	} probe_t;

	// Probes under reset settings; the extremes and zero are read straight off
	localparam probe_t PROBES [N_PROBES] = '{
		'{8'sh00, 1'b0, 1'b1, 8'sh00},
		'{8'sh7f, 1'b1, 1'b1, 8'sh7f},
		'{8'sh80, 1'b0, 1'b1, 8'sh80},
		'{8'shff, 1'b1, 1'b0, 8'sh00},
		'{8'sh01, 1'b0, 1'b0, 8'sh00},
		'{8'shfd, 1'b0, 1'b0, 8'sh00},
		'{8'sh03, 1'b1, 1'b0, 8'sh00},
		'{8'shfe, 1'b0, 1'b0, 8'sh00},
		'{8'sh02, 1'b0, 1'b0, 8'sh00},
		'{8'sh40, 1'b1, 1'b0, 8'sh00},
		'{8'shc0, 1'b0, 1'b0, 8'sh00},
		'{8'sh64, 1'b0, 1'b0, 8'sh00},
		'{8'sh9c, 1'b1, 1'b0, 8'sh00},
		'{8'sh2a, 1'b0, 1'b0, 8'sh00},
		'{8'shd6, 1'b0, 1'b0, 8'sh00},
		'{8'sh55, 1'b1, 1'b0, 8'sh00},
		'{8'shaa, 1'b0, 1'b0, 8'sh00},
		'{8'sh7e, 1'b1, 1'b0, 8'sh00}
	};

	// Planned settings ahead of the random ones
	localparam ihs_pkg::ihs_cfg_t CFG_PLAN [N_PLANNED] = '{
		// all fields at their extremes, gate exponent 15, output exponent -16
		'{8'sh7f, 16'sh8000, 16'sh8000, 5'sh0f, 5'sh10, 8'sh80},
		// gate exponent -16, positive output exponent (no shift)
		'{8'sh80, 16'sh7fff, 16'sh7fff, 5'sh10, 5'sh0f, 8'sh7f},
		// saturated gate meets a -32768 multiplier
		'{8'sh00, 16'sh4000, 16'sh8000, 5'sh0f, 5'sh00, 8'sh00},
		// smallest left shift, output shift by one so halves show up
		'{8'sh80, 16'sh8000, 16'sh7fff, 5'sh01, 5'sh1f, 8'sh00},
		// ordinary working point
		'{8'sh05, 16'sh5555, 16'sh2aab, 5'sh1d, 5'sh19, 8'shfb}
	};

	logic                           clk = 1'b0;
	logic                           arst_n;
	logic                           in_valid;
	logic                           in_ready;
	ihs_pkg::ihs_in_t               in_data;
	logic                           out_valid;
	logic                           out_ready;
	ihs_pkg::ihs_out_t              out_data;
	logic                           cfg_we;
	logic [ihs_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [ihs_pkg::CFG_DATA_W-1:0] cfg_wdata;

	ihs_pkg::ihs_cfg_t active_regs;
	ihs_pkg::ihs_out_t pending_results [$];
	ihs_pkg::ihs_out_t want_beat;
	int       mismatches = 0;
	int       cycles = 0;
	int       idle_pct = 0;
	int       stall_left = 0;
	bit       quiet = 1'b0;

	int8_hard_swish_activation dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always #6 clk = ~clk;

	// Run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_int8_hard_swish_activation failed");
			$finish;
		end
	end

	// Q15 multiply, round half up, saturating corner
	function automatic int round_high_mul(int a, int b);
		if (a == -32768 && b == -32768)
			return 32767;
		return (a * b + 16384) >>> 15;
	endfunction

	// Q15 multiply, truncating toward zero
	function automatic int trunc_high_mul(int a, int b);
		if (a == -32768 && b == -32768)
			return 32767;
		return (a * b) / 32768;
	endfunction

	function automatic int clamp_q15(int v);
		if (v > 32767)
			return 32767;
		if (v < -32768)
			return -32768;
		return v;
	endfunction

	// Divide by 2^e, halves rounded away from zero
	function automatic int round_div_pow2(int v, int e);
		int mask;
		int rem;
		int thr;
		mask = (1 << e) - 1;
		rem  = v & mask;
		thr  = (mask >>> 1) + ((v < 0) ? 1 : 0);
		return (v >>> e) + ((rem > thr) ? 1 : 0);
	endfunction

	// Expected result beat for one sample under the given settings
	function automatic ihs_pkg::ihs_out_t hard_swish(ihs_pkg::ihs_in_t beat,
			ihs_pkg::ihs_cfg_t c);
		int hires;
		int scaled;
		int gate;
		int prod;
		int gexp;
		int oexp;
		int y;
		ihs_pkg::ihs_out_t res;
		hires  = (int'(beat.sample) - int'(c.in_zero_point)) * 128;
		scaled = round_high_mul(hires, int'(c.out_scale_mult));
		gexp   = int'(c.gate_scale_exp);
		if (gexp > 0) begin
			gate = clamp_q15(hires << (gexp - 1));
			gate = round_high_mul(gate, int'(c.gate_scale_mult));
			gate = clamp_q15(gate * 2);
		end else begin
			gate = round_high_mul(hires, int'(c.gate_scale_mult));
			if (gexp < 0)
				gate = round_div_pow2(gate, -gexp);
		end
		// map gate from [-1,1] to [0,1]
		gate = (gate + 32768) >>> 1;
		prod = trunc_high_mul(gate, scaled);
		oexp = (int'(c.out_shift_exp) > 0) ? 0 : -int'(c.out_shift_exp);
		y    = round_div_pow2(prod, oexp) + int'(c.out_zero_point);
		if (y > 127)
			y = 127;
		if (y < -128)
			y = -128;
		res.result   = y[7:0];
		res.last_out = beat.last_in;
		return res;
	endfunction

	function automatic logic [7:0] pick8();
		case ($urandom_range(7))
			0: return 8'h80;
			1: return 8'h7f;
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic logic [15:0] pick16();
		case ($urandom_range(7))
			0: return 16'h8000;
			1: return 16'h7fff;
			default: return 16'($urandom);
		endcase
	endfunction

	// Receiver: ready drops in random bursts unless the run is in its quiet tail
	always @(negedge clk) begin
		if (quiet) begin
			out_ready <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else if ($urandom_range(99) < idle_pct) begin
			stall_left = $urandom_range(1, 9) - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// Result checker
	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				$error("result beat with none expected: result %0d last_out %0b",
					out_data.result, out_data.last_out);
				mismatches++;
			end else begin
				want_beat = pending_results.pop_front();
				if (out_data.result !== want_beat.result) begin
					$error("result: expected %0d, got %0d", want_beat.result, out_data.result);
					mismatches++;
				end
				if (out_data.last_out !== want_beat.last_out) begin
					$error("last_out: expected %0b, got %0b",
						want_beat.last_out, out_data.last_out);
					mismatches++;
				end
			end
		end
	end

	// One register write; the bench copy decodes it as the block should
	task automatic write_reg(input logic [ihs_pkg::CFG_IDX_W-1:0] idx,
			input logic [ihs_pkg::CFG_DATA_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		case (idx)
			ihs_pkg::REG_IN_ZERO_POINT:   active_regs.in_zero_point   = data[7:0];
			ihs_pkg::REG_OUT_SCALE_MULT:  active_regs.out_scale_mult  = data[15:0];
			ihs_pkg::REG_GATE_SCALE_MULT: active_regs.gate_scale_mult = data[15:0];
			ihs_pkg::REG_GATE_SCALE_EXP:  active_regs.gate_scale_exp  = data[4:0];
			ihs_pkg::REG_OUT_SHIFT_EXP:   active_regs.out_shift_exp   = data[4:0];
			ihs_pkg::REG_OUT_ZERO_POINT:  active_regs.out_zero_point  = data[7:0];
			default: ;
		endcase
		@(negedge clk);
	endtask

	// Full register set, junk in the unused upper bits, plus a stray write
	task automatic apply_cfg(input ihs_pkg::ihs_cfg_t c);
		write_reg(ihs_pkg::REG_IN_ZERO_POINT, {8'($urandom), c.in_zero_point});
		write_reg(ihs_pkg::REG_OUT_SCALE_MULT, c.out_scale_mult);
		write_reg($urandom_range(1) ? IDX_SPARE_B : IDX_SPARE_A, 16'($urandom));
		write_reg(ihs_pkg::REG_GATE_SCALE_MULT, c.gate_scale_mult);
		write_reg(ihs_pkg::REG_GATE_SCALE_EXP, {11'($urandom), c.gate_scale_exp});
		write_reg(ihs_pkg::REG_OUT_SHIFT_EXP, {11'($urandom), c.out_shift_exp});
		write_reg(ihs_pkg::REG_OUT_ZERO_POINT, {8'($urandom), c.out_zero_point});
		cfg_we <= 1'b0;
	endtask

	// Offer one beat, with an optional gap ahead of it; called at a falling edge
	task automatic send_beat(input ihs_pkg::ihs_in_t beat, input logic known,
			input logic signed [7:0] want);
		int gap;
		if (!quiet && $urandom_range(99) < idle_pct) begin
			gap = $urandom_range(1, 9);
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= beat;
		do @(posedge clk); while (!in_ready);
		if (known)
			pending_results.push_back(
				ihs_pkg::ihs_out_t'{result: want, last_out: beat.last_in});
		else
			pending_results.push_back(hard_swish(beat, active_regs));
		@(negedge clk);
	endtask

	// Hold off until every result is out and the pipeline has drained
	task automatic settle();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	initial begin
		ihs_pkg::ihs_cfg_t next_cfg;
		ihs_pkg::ihs_in_t  beat;
		int                nshift;
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		in_data   = '0;
		out_ready = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		active_regs = '{8'sh00, ihs_pkg::MULT_RST, ihs_pkg::MULT_RST, 5'sh00, 5'sh00, 8'sh00};
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Probe table under reset settings
		idle_pct = 10;
		for (int i = 0; i < N_PROBES; i++) begin
			beat.sample  = PROBES[i].sample;
			beat.last_in = PROBES[i].last;
			send_beat(beat, PROBES[i].known, PROBES[i].want);
		end

		// Planned settings first, then random ones
		for (int ph = 0; ph < N_PHASES; ph++) begin
			settle();
			if (ph < N_PLANNED) begin
				next_cfg = CFG_PLAN[ph];
			end else begin
				next_cfg.in_zero_point   = pick8();
				next_cfg.out_scale_mult  = pick16();
				next_cfg.gate_scale_mult = pick16();
				next_cfg.gate_scale_exp  = 5'($urandom);
				nshift = $urandom_range(0, 16);
				next_cfg.out_shift_exp   = ($urandom_range(3) == 0) ? 5'($urandom) : 5'(-nshift);
				next_cfg.out_zero_point  = pick8();
			end
			apply_cfg(next_cfg);
			quiet = (ph >= N_PHASES - 2);
			case ($urandom_range(3))
				0: idle_pct = 0;
				1: idle_pct = 5;
				2: idle_pct = 15;
				default: idle_pct = 30;
			endcase
			for (int k = 0; k < BEATS_PER_PHASE; k++) begin
				case ((k < 2) ? k : $urandom_range(2, 9))
					0: beat.sample = 8'sh80;
					1: beat.sample = 8'sh7f;
					2: beat.sample = active_regs.in_zero_point;
					default: beat.sample = 8'($urandom);
				endcase
				beat.last_in = ($urandom_range(7) == 0);
				send_beat(beat, 1'b0, 8'sh00);
			end
		end

		// Drain and report
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (mismatches == 0)
			$display("tb_int8_hard_swish_activation passed");
		else
			$display("tb_int8_hard_swish_activation failed");
		$finish;
	end

endmodule
